// ===== src/area_height_and_point_distance_defines.svh =====
// ----------------------------------------------------------------------------
// Area height and point distance: assertion macros
// Shared assertion forms for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef AREA_HEIGHT_AND_POINT_DISTANCE_DEFINES_SVH
`define AREA_HEIGHT_AND_POINT_DISTANCE_DEFINES_SVH

// Checked only out of reset
`define AHPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define AHPD_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ahpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ahpd_pkg
// Types and constants of the area height and point distance block.
// ----------------------------------------------------------------------------
package ahpd_pkg;

  localparam int COORD_W   = 24;             // coordinate and height width
  localparam int MAG_W     = COORD_W + 1;    // difference of two coordinates
  localparam int UV_BITS   = 16;             // fraction width of u and v
  localparam int DIST_W    = 2 * MAG_W;      // squared distance width
  localparam int PROD_W    = MAG_W + UV_BITS + 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X     = 3'd0,
    REG_MIN_Y     = 3'd1,
    REG_MAX_X     = 3'd2,
    REG_MAX_Y     = 3'd3,
    REG_NW_HEIGHT = 3'd4,
    REG_NE_HEIGHT = 3'd5,
    REG_SW_HEIGHT = 3'd6,
    REG_SE_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } in_t;

  typedef struct packed {
    coord_t              surface_height;
    logic [DIST_W-1:0]   distance_sq;
    logic                inside_flag;
    coord_t              nearest_x;
    coord_t              nearest_y;
    coord_t              nearest_z;
  } out_t;

endpackage

// ===== src/area_height_and_point_distance.sv =====
// ----------------------------------------------------------------------------
// area_height_and_point_distance
// Height, nearest point, containment and squared distance of a query point
// against one configured rectangular area.
// ----------------------------------------------------------------------------
// One query point enters per clock and one result leaves per clock while the
// pipe moves; each point passes the input register, region split, squaring,
// sum, sixteen restoring-division stages for the u and v fractions, and five
// stages of bilinear interpolation and final squaring.
// The sixteen division stages set the depth: one quotient bit per stage for
// both fractions side by side. The whole pipe moves together; it holds only
// while a finished result waits with out_stall high, so in_stall is exactly
// that condition. Configuration registers take a write in every cycle.
// ----------------------------------------------------------------------------
module area_height_and_point_distance (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ahpd_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ahpd_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ahpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  ahpd_pkg::coord_t                   cfg_data
);
  import ahpd_pkg::*;

  // Region split results plus fraction division seeds
  typedef struct packed {
    coord_t              pz;
    coord_t              cx;
    coord_t              cy;
    logic                over;     // x and y inside the bounds
    logic                degen;    // zero or inverted side
    logic                ufull;
    logic                vfull;
    logic [MAG_W-1:0]    ax;
    logic [MAG_W-1:0]    ay;
    logic [MAG_W-1:0]    az;
    logic [COORD_W-1:0]  urem;
    logic [COORD_W-1:0]  vrem;
  } s1_t;

  typedef struct packed {
    coord_t              pz;
    coord_t              cx;
    coord_t              cy;
    logic                over;
    logic                degen;
    logic                ufull;
    logic                vfull;
    logic [DIST_W-1:0]   sqx;
    logic [DIST_W-1:0]   sqy;
    logic [DIST_W-1:0]   sqz;
    logic [COORD_W-1:0]  urem;
    logic [COORD_W-1:0]  vrem;
  } s2_t;

  typedef struct packed {
    coord_t              pz;
    coord_t              cx;
    coord_t              cy;
    logic                over;
    logic                degen;
    logic                ufull;
    logic                vfull;
    logic [DIST_W-1:0]   dsq;
    logic [COORD_W-1:0]  urem;
    logic [COORD_W-1:0]  vrem;
    logic [UV_BITS-1:0]  uq;
    logic [UV_BITS-1:0]  vq;
  } div_t;

  typedef struct packed {
    coord_t                    pz;
    coord_t                    cx;
    coord_t                    cy;
    logic                      over;
    logic                      degen;
    logic [DIST_W-1:0]         dsq;
    logic [UV_BITS:0]          v;
    logic signed [PROD_W-1:0]  np;
    logic signed [PROD_W-1:0]  sp;
  } l1_t;

  typedef struct packed {
    coord_t                    pz;
    coord_t                    cx;
    coord_t                    cy;
    logic                      over;
    logic                      degen;
    logic [DIST_W-1:0]         dsq;
    logic [UV_BITS:0]          v;
    coord_t                    north;
    logic signed [MAG_W-1:0]   sndiff;
  } l2_t;

  typedef struct packed {
    coord_t                    pz;
    coord_t                    cx;
    coord_t                    cy;
    logic                      over;
    logic                      degen;
    logic [DIST_W-1:0]         dsq;
    coord_t                    north;
    logic signed [PROD_W-1:0]  vp;
  } l3_t;

  typedef struct packed {
    coord_t                    pz;
    coord_t                    cx;
    coord_t                    cy;
    logic                      over;
    logic [DIST_W-1:0]         dsq;
    coord_t                    h;
  } l4_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] d);
    mag = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  coord_t min_x_r, min_y_r, max_x_r, max_y_r;
  coord_t nw_r, ne_r, sw_r, se_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      min_y_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      nw_r    <= '0;
      ne_r    <= '0;
      sw_r    <= '0;
      se_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_X:     min_x_r <= cfg_data;
        REG_MIN_Y:     min_y_r <= cfg_data;
        REG_MAX_X:     max_x_r <= cfg_data;
        REG_MAX_Y:     max_y_r <= cfg_data;
        REG_NW_HEIGHT: nw_r    <= cfg_data;
        REG_NE_HEIGHT: ne_r    <= cfg_data;
        REG_SW_HEIGHT: sw_r    <= cfg_data;
        REG_SE_HEIGHT: se_r    <= cfg_data;
      endcase
    end
  end

  // Divisors for the division stages; only meaningful when the area is
  // proper, and settled before a point sent after a write reaches a divide step.
  logic [COORD_W-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    dx_r <= COORD_W'(max_x_r - min_x_r);
    dy_r <= COORD_W'(max_y_r - min_y_r);
  end

  // --------------------------------------------------------------------------
  // Pipe advance: all stages move unless a result is held at the output.
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // S0: input register
  // --------------------------------------------------------------------------
  logic s0_vld_r;
  in_t  s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s0_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // S1: region split, clamp, fraction seeds
  // --------------------------------------------------------------------------
  logic                    s1_vld_r;
  s1_t                     s1_r, s1_nxt;
  logic signed [MAG_W-1:0] dxs, dys, unum, vnum;
  logic signed [MAG_W-1:0] zdiff;
  logic                    xw, xe, yn, ys;
  coord_t                  cx1, cy1, corner_h;

  always_comb begin
    dxs  = MAG_W'(max_x_r) - MAG_W'(min_x_r);
    dys  = MAG_W'(max_y_r) - MAG_W'(min_y_r);
    unum = MAG_W'(s0_r.point_x) - MAG_W'(min_x_r);
    vnum = MAG_W'(s0_r.point_y) - MAG_W'(min_y_r);

    xw = s0_r.point_x < min_x_r;
    xe = s0_r.point_x > max_x_r;
    yn = s0_r.point_y < min_y_r;
    ys = s0_r.point_y > max_y_r;

    // north wins over south when the bounds are inverted
    priority if (xw && yn) corner_h = nw_r;
    else if (xw)           corner_h = sw_r;
    else if (yn)           corner_h = ne_r;
    else                   corner_h = se_r;
    zdiff = MAG_W'(corner_h) - MAG_W'(s0_r.point_z);

    s1_nxt.pz   = s0_r.point_z;
    s1_nxt.over = !xw && !xe && !yn && !ys;
    s1_nxt.degen = (dxs <= 0) || (dys <= 0);

    cx1 = xw ? min_x_r : s0_r.point_x;
    cy1 = yn ? min_y_r : s0_r.point_y;
    s1_nxt.cx = (cx1 >= max_x_r) ? max_x_r : cx1;
    s1_nxt.cy = (cy1 >= max_y_r) ? max_y_r : cy1;

    if (xw)      s1_nxt.ax = MAG_W'(MAG_W'(min_x_r) - MAG_W'(s0_r.point_x));
    else if (xe) s1_nxt.ax = MAG_W'(MAG_W'(s0_r.point_x) - MAG_W'(max_x_r));
    else         s1_nxt.ax = '0;
    if (yn)      s1_nxt.ay = MAG_W'(MAG_W'(min_y_r) - MAG_W'(s0_r.point_y));
    else if (ys) s1_nxt.ay = MAG_W'(MAG_W'(s0_r.point_y) - MAG_W'(max_y_r));
    else         s1_nxt.ay = '0;
    s1_nxt.az = ((xw || xe) && (yn || ys)) ? mag(zdiff) : '0;

    // fraction saturates at zero and one; only the open interval is divided
    s1_nxt.ufull = unum >= dxs;
    s1_nxt.vfull = vnum >= dys;
    s1_nxt.urem  = (unum <= 0 || s1_nxt.ufull) ? '0 : unum[COORD_W-1:0];
    s1_nxt.vrem  = (vnum <= 0 || s1_nxt.vfull) ? '0 : vnum[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // S2: squares of the gaps
  // --------------------------------------------------------------------------
  logic s2_vld_r;
  s2_t  s2_r, s2_nxt;

  always_comb begin
    s2_nxt.pz    = s1_r.pz;
    s2_nxt.cx    = s1_r.cx;
    s2_nxt.cy    = s1_r.cy;
    s2_nxt.over  = s1_r.over;
    s2_nxt.degen = s1_r.degen;
    s2_nxt.ufull = s1_r.ufull;
    s2_nxt.vfull = s1_r.vfull;
    s2_nxt.urem  = s1_r.urem;
    s2_nxt.vrem  = s1_r.vrem;
    s2_nxt.sqx   = DIST_W'(s1_r.ax) * DIST_W'(s1_r.ax);
    s2_nxt.sqy   = DIST_W'(s1_r.ay) * DIST_W'(s1_r.ay);
    s2_nxt.sqz   = DIST_W'(s1_r.az) * DIST_W'(s1_r.az);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // S3: distance sum, division entry (div_r[0])
  // --------------------------------------------------------------------------
  logic div_vld_r [0:UV_BITS];
  div_t div_r     [0:UV_BITS];
  div_t div0_nxt;

  always_comb begin
    div0_nxt.pz    = s2_r.pz;
    div0_nxt.cx    = s2_r.cx;
    div0_nxt.cy    = s2_r.cy;
    div0_nxt.over  = s2_r.over;
    div0_nxt.degen = s2_r.degen;
    div0_nxt.ufull = s2_r.ufull;
    div0_nxt.vfull = s2_r.vfull;
    div0_nxt.urem  = s2_r.urem;
    div0_nxt.vrem  = s2_r.vrem;
    div0_nxt.uq    = '0;
    div0_nxt.vq    = '0;
    div0_nxt.dsq   = s2_r.sqx + s2_r.sqy + s2_r.sqz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else if (adv) begin
      div_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Division: one quotient bit of u and of v per stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < UV_BITS; k++) begin : g_div
    div_t             step_nxt;
    logic [COORD_W:0] ur2, vr2;
    logic             uge, vge;

    always_comb begin
      ur2 = {div_r[k].urem, 1'b0};
      vr2 = {div_r[k].vrem, 1'b0};
      uge = ur2 >= {1'b0, dx_r};
      vge = vr2 >= {1'b0, dy_r};
      step_nxt      = div_r[k];
      step_nxt.urem = uge ? COORD_W'(ur2 - {1'b0, dx_r}) : ur2[COORD_W-1:0];
      step_nxt.vrem = vge ? COORD_W'(vr2 - {1'b0, dy_r}) : vr2[COORD_W-1:0];
      step_nxt.uq   = {div_r[k].uq[UV_BITS-2:0], uge};
      step_nxt.vq   = {div_r[k].vq[UV_BITS-2:0], vge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        div_vld_r[k+1] <= div_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k+1] <= step_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // L1: edge products (ne - nw) * u and (se - sw) * u
  // --------------------------------------------------------------------------
  logic                      l1_vld_r;
  l1_t                       l1_r, l1_nxt;
  logic [UV_BITS:0]          u_full;
  logic signed [UV_BITS+1:0] us;
  logic signed [MAG_W-1:0]   ndiff, sdiff;

  always_comb begin
    u_full = div_r[UV_BITS].ufull ? {1'b1, {UV_BITS{1'b0}}}
                                  : {1'b0, div_r[UV_BITS].uq};
    us     = {1'b0, u_full};
    ndiff  = MAG_W'(ne_r) - MAG_W'(nw_r);
    sdiff  = MAG_W'(se_r) - MAG_W'(sw_r);

    l1_nxt.pz    = div_r[UV_BITS].pz;
    l1_nxt.cx    = div_r[UV_BITS].cx;
    l1_nxt.cy    = div_r[UV_BITS].cy;
    l1_nxt.over  = div_r[UV_BITS].over;
    l1_nxt.degen = div_r[UV_BITS].degen;
    l1_nxt.dsq   = div_r[UV_BITS].dsq;
    l1_nxt.v     = div_r[UV_BITS].vfull ? {1'b1, {UV_BITS{1'b0}}}
                                        : {1'b0, div_r[UV_BITS].vq};
    l1_nxt.np    = PROD_W'(ndiff) * PROD_W'(us);
    l1_nxt.sp    = PROD_W'(sdiff) * PROD_W'(us);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_vld_r <= 1'b0;
    end else if (adv) begin
      l1_vld_r <= div_vld_r[UV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r <= l1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // L2: north and south edge heights (arithmetic shift = floor)
  // --------------------------------------------------------------------------
  logic                     l2_vld_r;
  l2_t                      l2_r, l2_nxt;
  logic signed [PROD_W-1:0] nsh, ssh;
  coord_t                   south;

  always_comb begin
    nsh   = l1_r.np >>> UV_BITS;
    ssh   = l1_r.sp >>> UV_BITS;
    south = coord_t'(sw_r + COORD_W'(ssh));

    l2_nxt.pz     = l1_r.pz;
    l2_nxt.cx     = l1_r.cx;
    l2_nxt.cy     = l1_r.cy;
    l2_nxt.over   = l1_r.over;
    l2_nxt.degen  = l1_r.degen;
    l2_nxt.dsq    = l1_r.dsq;
    l2_nxt.v      = l1_r.v;
    l2_nxt.north  = coord_t'(nw_r + COORD_W'(nsh));
    l2_nxt.sndiff = MAG_W'(south) - MAG_W'(l2_nxt.north);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_vld_r <= 1'b0;
    end else if (adv) begin
      l2_vld_r <= l1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_r <= l2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // L3: (south - north) * v
  // --------------------------------------------------------------------------
  logic                      l3_vld_r;
  l3_t                       l3_r, l3_nxt;
  logic signed [UV_BITS+1:0] vs;

  always_comb begin
    vs           = {1'b0, l2_r.v};
    l3_nxt.pz    = l2_r.pz;
    l3_nxt.cx    = l2_r.cx;
    l3_nxt.cy    = l2_r.cy;
    l3_nxt.over  = l2_r.over;
    l3_nxt.degen = l2_r.degen;
    l3_nxt.dsq   = l2_r.dsq;
    l3_nxt.north = l2_r.north;
    l3_nxt.vp    = PROD_W'(l2_r.sndiff) * PROD_W'(vs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l3_vld_r <= 1'b0;
    end else if (adv) begin
      l3_vld_r <= l2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l3_r <= l3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // L4: surface height; degenerate area takes the north-east height
  // --------------------------------------------------------------------------
  logic                     l4_vld_r;
  l4_t                      l4_r, l4_nxt;
  logic signed [PROD_W-1:0] vsh;

  always_comb begin
    vsh         = l3_r.vp >>> UV_BITS;
    l4_nxt.pz   = l3_r.pz;
    l4_nxt.cx   = l3_r.cx;
    l4_nxt.cy   = l3_r.cy;
    l4_nxt.over = l3_r.over;
    l4_nxt.dsq  = l3_r.dsq;
    l4_nxt.h    = l3_r.degen ? ne_r : coord_t'(l3_r.north + COORD_W'(vsh));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l4_vld_r <= 1'b0;
    end else if (adv) begin
      l4_vld_r <= l3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l4_r <= l4_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // L5: output register. Over the area the distance is the vertical gap.
  // The clamped point always yields the same fractions as the query point,
  // so the nearest height equals the surface height.
  // --------------------------------------------------------------------------
  out_t                    out_r, out_nxt;
  logic signed [MAG_W-1:0] hz;
  logic [DIST_W-1:0]       hz_sq;

  always_comb begin
    hz    = MAG_W'(l4_r.h) - MAG_W'(l4_r.pz);
    hz_sq = DIST_W'(mag(hz)) * DIST_W'(mag(hz));

    out_nxt.surface_height = l4_r.h;
    out_nxt.distance_sq    = l4_r.over ? hz_sq : l4_r.dsq;
    out_nxt.inside_flag    = l4_r.over && (l4_r.h <= l4_r.pz);
    out_nxt.nearest_x      = l4_r.cx;
    out_nxt.nearest_y      = l4_r.cy;
    out_nxt.nearest_z      = l4_r.h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= l4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/ahpd_checker.sv =====
// ----------------------------------------------------------------------------
// ahpd_checker
// Port-level checks of the area height and point distance block.
// ----------------------------------------------------------------------------
`include "area_height_and_point_distance_defines.svh"

module ahpd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ahpd_pkg::out_t out_data
);

  // input side holds exactly while a result waits
  `AHPD_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "in_stall mismatch")

  // a held result keeps its value
  `AHPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed")

  // reset empties the pipe
  `AHPD_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind area_height_and_point_distance ahpd_checker u_ahpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/area_height_and_point_distance_tb.sv =====
// ----------------------------------------------------------------------------
// area_height_and_point_distance_tb
// Self-checking bench: drives query points against a series of area settings
// (reset values, ordinary, extreme, flat and inverted bounds) and checks every
// result field against a behavioral predictor of the interpolation, clamping
// and region-split distance, or typed directed rows against their answers.
// Random gaps on both channels, one long output hold and one drain pause.
// ----------------------------------------------------------------------------
module area_height_and_point_distance_tb;
  import ahpd_pkg::*;

  localparam longint CMIN  = -(64'sd1 <<< 23);
  localparam longint CMAX  = (64'sd1 <<< 23) - 1;
  localparam int     DRAIN = 40;
  localparam int     LIMIT = 400000;     // cycle budget for the whole run

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  in_t    in_data;
  logic   out_valid;
  logic   out_stall;
  out_t   out_data;
  logic   cfg_valid;
  logic   cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  coord_t cfg_data;

  area_height_and_point_distance DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the area registers, updated on each cfg transfer
  longint area_min_x, area_min_y, area_max_x, area_max_y;
  longint h_nw, h_ne, h_sw, h_se;

  out_t   pending_results[$];  // results owed by the block, oldest first
  int     fail_count;
  int     cycle_count = 0;
  bit     long_hold_req;       // receiver should hold off for a long stretch
  bit     steady_send;         // sender offers back to back
  int     stall_pct;           // receiver stall odds per phase

  // Directed rows, all run against the reset area (flat, at the origin).
  // Typed rows carry the obvious answer: height 0, nearest point 0,0,0.
  typedef struct {
    longint px, py, pz;
    bit     typed;
    longint dsq;
    bit     in_area;
  } dir_row_t;

  localparam int NDIR = 20;
  dir_row_t dir_rows [NDIR] = '{
    '{0, 0, 0, 1, 0, 1},
    '{0, 0, -256, 1, 65536, 0},
    '{0, 0, 256, 1, 65536, 1},
    '{-256, 0, 0, 1, 65536, 0},
    '{256, 0, 0, 1, 65536, 0},
    '{0, -256, 0, 1, 65536, 0},
    '{0, 256, 0, 1, 65536, 0},
    '{CMIN, 0, 0, 1, 64'd70368744177664, 0},
    '{-256, -256, 5, 0, 0, 0},
    '{256, 256, -7, 0, 0, 0},
    '{-256, 256, 0, 0, 0, 0},
    '{256, -256, 0, 0, 0, 0},
    '{CMIN, CMIN, CMAX, 0, 0, 0},
    '{CMAX, CMAX, CMIN, 0, 0, 0},
    '{CMAX, CMIN, CMAX, 0, 0, 0},
    '{CMIN, CMAX, CMIN, 0, 0, 0},
    '{0, 0, CMIN, 0, 0, 0},
    '{0, 0, CMAX, 0, 0, 0},
    '{-1, -1, -1, 0, 0, 0},
    '{CMAX, 0, 0, 0, 0, 0}
  };

  // ---------------------------------------------------------------- predictor

  // u or v fraction: 0..2^16, clamped, truncating division
  function automatic longint uv_fraction(longint num, longint den);
    if (num <= 0) return 0;
    if (num >= den) return 64'sd1 <<< UV_BITS;
    return (num <<< UV_BITS) / den;
  endfunction

  // a + floor((b - a) * t / 2^16)
  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> UV_BITS);
  endfunction

  function automatic longint area_height(longint x, longint y);
    longint dx, dy, u, v, north, south;
    dx = area_max_x - area_min_x;
    dy = area_max_y - area_min_y;
    if (dx <= 0 || dy <= 0) return h_ne;  // flat or inverted area
    u = uv_fraction(x - area_min_x, dx);
    v = uv_fraction(y - area_min_y, dy);
    north = blend(h_nw, h_ne, u);
    south = blend(h_sw, h_se, u);
    return blend(north, south, v);
  endfunction

  function automatic longint squared(longint d);
    return d * d;
  endfunction

  function automatic out_t area_query(in_t pt);
    longint px, py, pz, h, cx, cy, dsq;
    out_t   r;
    px = longint'(pt.point_x);
    py = longint'(pt.point_y);
    pz = longint'(pt.point_z);
    h  = area_height(px, py);

    // nine-region split, west/east tested first
    if (px < area_min_x) begin
      if (py < area_min_y)
        dsq = squared(area_min_x - px) + squared(area_min_y - py) + squared(h_nw - pz);
      else if (py > area_max_y)
        dsq = squared(area_min_x - px) + squared(area_max_y - py) + squared(h_sw - pz);
      else
        dsq = squared(area_min_x - px);
    end else if (px > area_max_x) begin
      if (py < area_min_y)
        dsq = squared(area_max_x - px) + squared(area_min_y - py) + squared(h_ne - pz);
      else if (py > area_max_y)
        dsq = squared(area_max_x - px) + squared(area_max_y - py) + squared(h_se - pz);
      else
        dsq = squared(px - area_max_x);
    end else if (py < area_min_y) begin
      dsq = squared(area_min_y - py);
    end else if (py > area_max_y) begin
      dsq = squared(py - area_max_y);
    end else begin
      dsq = squared(h - pz);
    end

    // clamp raises to min first, then anything at or past max lands on max
    cx = (px < area_min_x) ? area_min_x : px;
    if (cx >= area_max_x) cx = area_max_x;
    cy = (py < area_min_y) ? area_min_y : py;
    if (cy >= area_max_y) cy = area_max_y;

    r.surface_height = coord_t'(h);
    r.distance_sq    = dsq[DIST_W-1:0];
    r.inside_flag    = (px >= area_min_x && px <= area_max_x &&
                        py >= area_min_y && py <= area_max_y && h <= pz);
    r.nearest_x      = coord_t'(cx);
    r.nearest_y      = coord_t'(cy);
    r.nearest_z      = coord_t'(area_height(cx, cy));
    return r;
  endfunction

  // ---------------------------------------------------------------- clock

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
      $display("area_height_and_point_distance_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  // Stall pattern is decided at the falling edge, results taken at the
  // rising edge. A long hold request is counted out here in cycles.
  initial begin : receiver
    int   hold_left;
    out_t want;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 99) < stall_pct)
          hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.surface_height !== want.surface_height) begin
            $display("%0t: surface_height expected %0d actual %0d", $time,
                     want.surface_height, out_data.surface_height);
            fail_count++;
          end
          if (out_data.distance_sq !== want.distance_sq) begin
            $display("%0t: distance_sq expected %0d actual %0d", $time,
                     want.distance_sq, out_data.distance_sq);
            fail_count++;
          end
          if (out_data.inside_flag !== want.inside_flag) begin
            $display("%0t: inside_flag expected %0b actual %0b", $time,
                     want.inside_flag, out_data.inside_flag);
            fail_count++;
          end
          if (out_data.nearest_x !== want.nearest_x) begin
            $display("%0t: nearest_x expected %0d actual %0d", $time,
                     want.nearest_x, out_data.nearest_x);
            fail_count++;
          end
          if (out_data.nearest_y !== want.nearest_y) begin
            $display("%0t: nearest_y expected %0d actual %0d", $time,
                     want.nearest_y, out_data.nearest_y);
            fail_count++;
          end
          if (out_data.nearest_z !== want.nearest_z) begin
            $display("%0t: nearest_z expected %0d actual %0d", $time,
                     want.nearest_z, out_data.nearest_z);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender side

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_point(in_t pt, bit typed, out_t typed_result);
    in_valid = 1'b1;
    in_data  = pt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? typed_result : area_query(pt));
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (steady_send) return;
    case ($urandom_range(0, 19))
      0:       n = $urandom_range(10, 40);
      1, 2, 3,
      4, 5:    n = $urandom_range(1, 3);
      default: n = 0;
    endcase
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Wait until every owed result is back and the pipe has emptied
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, longint value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = coord_t'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_X:     area_min_x = longint'(coord_t'(value));
      REG_MIN_Y:     area_min_y = longint'(coord_t'(value));
      REG_MAX_X:     area_max_x = longint'(coord_t'(value));
      REG_MAX_Y:     area_max_y = longint'(coord_t'(value));
      REG_NW_HEIGHT: h_nw = longint'(coord_t'(value));
      REG_NE_HEIGHT: h_ne = longint'(coord_t'(value));
      REG_SW_HEIGHT: h_sw = longint'(coord_t'(value));
      REG_SE_HEIGHT: h_se = longint'(coord_t'(value));
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_area(longint mnx, longint mny, longint mxx, longint mxy,
                          longint nw, longint ne, longint sw, longint se);
    wait_idle();
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MAX_Y, mxy);
    write_reg(REG_NW_HEIGHT, nw);
    write_reg(REG_NE_HEIGHT, ne);
    write_reg(REG_SW_HEIGHT, sw);
    write_reg(REG_SE_HEIGHT, se);
    cfg_valid = 1'b0;
  endtask

  function automatic longint rand_between(longint lo, longint hi);
    if (hi <= lo) return lo;
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic longint rand_coord();
    return rand_between(CMIN, CMAX);
  endfunction

  // Coordinate biased toward the area: near or on its edges, or anywhere
  function automatic longint pick_axis(longint a, longint b);
    longint lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_between(lo, hi);
      4:          return a;
      5:          return b;
      6:          return a + $urandom_range(0, 2) - 1;
      7:          return b + $urandom_range(0, 2) - 1;
      8:          return rand_between(lo - 4096, hi + 4096);
      default:    return rand_coord();
    endcase
  endfunction

  task automatic random_points(int count);
    in_t  pt;
    out_t none;
    longint z;
    none = '0;
    repeat (count) begin
      pt.point_x = coord_t'(pick_axis(area_min_x, area_max_x));
      pt.point_y = coord_t'(pick_axis(area_min_y, area_max_y));
      // z near the surface so the inside flag goes both ways
      case ($urandom_range(0, 3))
        0:       z = rand_coord();
        default: z = area_height(longint'(pt.point_x), longint'(pt.point_y))
                     + $urandom_range(0, 512) - 256;
      endcase
      pt.point_z = coord_t'(z);
      send_point(pt, 1'b0, none);
      sender_gap();
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin : stimulus
    in_t  pt;
    out_t typed_result;
    fail_count    = 0;
    long_hold_req = 1'b0;
    steady_send   = 1'b0;
    stall_pct     = 15;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    area_min_x = 0; area_min_y = 0; area_max_x = 0; area_max_y = 0;
    h_nw = 0; h_ne = 0; h_sw = 0; h_se = 0;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows against the reset area
    foreach (dir_rows[i]) begin
      pt.point_x = coord_t'(dir_rows[i].px);
      pt.point_y = coord_t'(dir_rows[i].py);
      pt.point_z = coord_t'(dir_rows[i].pz);
      typed_result = '0;
      typed_result.distance_sq = dir_rows[i].dsq[DIST_W-1:0];
      typed_result.inside_flag = dir_rows[i].in_area;
      send_point(pt, dir_rows[i].typed, typed_result);
      sender_gap();
    end

    // Ordinary sloped area
    set_area(-25600, -12800, 25600, 38400, 1000, -3000, 5000, 256);
    random_points(200);

    // Long receiver hold while the sender keeps offering
    steady_send = 1'b1;
    long_hold_req = 1'b1;
    random_points(150);
    steady_send = 1'b0;

    // Sender drains fully mid-phase, then resumes
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    random_points(100);

    // Full-range bounds with extreme corner heights
    set_area(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX);
    random_points(200);

    // Flat in x: height is the north-east value everywhere
    set_area(512, -512, 512, 4096, 77, -9999, 300, 400);
    random_points(120);

    // Inverted bounds
    set_area(10000, 20000, -10000, -20000, 1, 2, 3, 4);
    random_points(120);

    // Tiny area, quiet receiver
    stall_pct = 0;
    set_area(-3, 5, 2, 9, -8388608, 8388607, 0, -1);
    random_points(150);

    // Random areas, heavier stalling
    stall_pct = 40;
    repeat (3) begin
      set_area(rand_between(CMIN, 0), rand_between(CMIN, 0),
               rand_between(0, CMAX), rand_between(0, CMAX),
               rand_coord(), rand_coord(), rand_coord(), rand_coord());
      random_points(120);
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    if (fail_count == 0)
      $display("area_height_and_point_distance_tb OK");
    else
      $display("area_height_and_point_distance_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ahpd_pkg.sv
src/area_height_and_point_distance.sv
src/ahpd_checker.sv
verif/area_height_and_point_distance_tb.sv
